// ===== design/ccpb_pkg.sv =====
// shared constants and types for the controller to program/bank translator
package ccpb_pkg;

    // default number of mapped channels
    localparam int DEF_CHANNELS = 16;

    // midi status codes
    localparam logic [3:0] CC_NIBBLE   = 4'hB;
    localparam logic [3:0] PC_NIBBLE   = 4'hC;
    localparam logic [1:0] CC_LENGTH   = 2'd3;
    localparam logic [1:0] PC_LENGTH   = 2'd2;
    localparam logic [1:0] FULL_COUNT  = 2'd3;

    // controller numbers
    localparam logic [6:0] PC_BASE     = 7'd1;
    localparam logic [6:0] LSB_BASE    = 7'd21;
    localparam logic [6:0] MSB_BASE    = 7'd41;
    localparam logic [6:0] CC_BANK_MSB = 7'd0;
    localparam logic [6:0] CC_BANK_LSB = 7'd32;

    // stream payload widths
    localparam int DATA_W = 24;

    // result sequence of one job
    typedef enum logic [1:0] {
        STEP_MSB,
        STEP_LSB,
        STEP_PC
    } t_step;

endpackage

// ===== design/midi_cc_to_program_bank_translator.sv =====
// top level of the midi controller to program/bank translator
// Input stream (s_axis) carries one received midi message per transfer.
// Control changes on controllers 1..CHANNELS give one program change on
// channel n-1. Controllers 21.. and 41.. store the bank lsb / msb of a channel
// and then give three messages: cc0 with the msb, cc32 with the lsb and
// program change 0. Output stream (m_axis) carries one message per transfer,
// tlast on the final message caused by an input transfer.
// Bank tables sit in two small synchronous memories; a store
// writes one table and reads both at the same edge.
// The first result is registered in the job registers and then in the output register before it is valid.
// Throughput: one input per cycle for ignored messages and program changes
// while the receiver does not stall; a bank store holds the next input back
// until its program change enters the output register, as the output port sends one message per cycle.
// Reset clears the output enable and the table valid bits, so every table
// entry reads as zero until written; no clearing pass is needed.
// When the receiver stalls, the result in the output register holds and the
// job behind it waits; the input side keeps taking transfers until a job is
// pending behind the output register.
// Config writes (i_cfg_we) set the output enable; when zero, stores still happen, nothing is sent.
module midi_cc_to_program_bank_translator #(
    parameter int CHANNELS = ccpb_pkg::DEF_CHANNELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config register: output_enabled
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // status_byte[7:0], first_data[14:8], second_data[21:15], byte_count[23:22]
    input  logic [ccpb_pkg::DATA_W-1:0] i_s_axis_tdata,
    // output stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // out_status[7:0], out_first[14:8], out_second[21:15], out_length[23:22]
    output logic [ccpb_pkg::DATA_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);
    import ccpb_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] PC_TOP  = 7'(CHANNELS);
    localparam logic [6:0] LSB_TOP = LSB_BASE + 7'(CHANNELS - 1);
    localparam logic [6:0] MSB_TOP = MSB_BASE + 7'(CHANNELS - 1);

    // input fields
    logic [7:0] in_status;
    logic [6:0] in_ctl;
    logic [6:0] in_val;
    logic [1:0] in_count;
    assign in_status = i_s_axis_tdata[7:0];
    assign in_ctl    = i_s_axis_tdata[14:8];
    assign in_val    = i_s_axis_tdata[21:15];
    assign in_count  = i_s_axis_tdata[23:22];

    // config register
    logic r_output_enabled;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            r_output_enabled <= i_cfg_wdata;
        end
    end

    // bank tables and their valid bits
    logic [6:0] r_msb_mem [CHANNELS];
    logic [6:0] r_lsb_mem [CHANNELS];
    logic [CHANNELS-1:0] r_msb_vld;
    logic [CHANNELS-1:0] r_lsb_vld;

    // job and output registers
    logic            r_job_valid;
    t_step           r_step;
    logic [CH_W-1:0] r_ch;
    logic [6:0]      r_prog;
    logic [6:0]      r_val;
    logic            r_fwd_msb;
    logic            r_fwd_lsb;
    logic [6:0]      r_rd_msb;
    logic [6:0]      r_rd_lsb;
    logic            r_rd_msb_v;
    logic            r_rd_lsb_v;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_last;

    // decode
    logic            is_cc, is_pc, is_lsb, is_msb, is_store, s_accept, out_free;
    logic [6:0]      pc_off, lsb_off, msb_off;
    logic [CH_W-1:0] st_ch, new_ch;

    always_comb begin
        is_cc    = (in_count == FULL_COUNT) && (in_status[7:4] == CC_NIBBLE);
        is_pc    = is_cc && (in_ctl >= PC_BASE) && (in_ctl <= PC_TOP);
        is_lsb   = is_cc && (in_ctl >= LSB_BASE) && (in_ctl <= LSB_TOP);
        is_msb   = is_cc && (in_ctl >= MSB_BASE) && (in_ctl <= MSB_TOP);
        is_store = is_lsb || is_msb;
        pc_off   = in_ctl - PC_BASE;
        lsb_off  = in_ctl - LSB_BASE;
        msb_off  = in_ctl - MSB_BASE;
        st_ch    = is_lsb ? lsb_off[CH_W-1:0] : msb_off[CH_W-1:0];
        new_ch   = is_pc ? pc_off[CH_W-1:0] : st_ch;
    end

    // handshake
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_job_valid || ((r_step == STEP_PC) && out_free);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // table write and read of both tables
    always_ff @(posedge i_clk) begin
        if (s_accept && is_store) begin
            if (is_lsb) begin
                r_lsb_mem[st_ch] <= in_val;
            end else begin
                r_msb_mem[st_ch] <= in_val;
            end
            r_rd_msb   <= r_msb_mem[st_ch];
            r_rd_lsb   <= r_lsb_mem[st_ch];
            r_rd_msb_v <= r_msb_vld[st_ch];
            r_rd_lsb_v <= r_lsb_vld[st_ch];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_vld <= '0;
            r_lsb_vld <= '0;
        end else if (s_accept && is_store) begin
            if (is_lsb) begin
                r_lsb_vld[st_ch] <= 1'b1;
            end else begin
                r_msb_vld[st_ch] <= 1'b1;
            end
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ch      <= new_ch;
            r_prog    <= is_pc ? in_val : 7'd0;
            r_val     <= in_val;
            r_fwd_msb <= is_msb;
            r_fwd_lsb <= is_lsb;
        end
    end

    // job control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_step      <= STEP_PC;
        end else if (s_accept) begin
            r_job_valid <= r_output_enabled && (is_pc || is_store);
            r_step      <= is_pc ? STEP_PC : STEP_MSB;
        end else if (r_job_valid && out_free) begin
            unique case (r_step)
                STEP_MSB: r_step      <= STEP_LSB;
                STEP_LSB: r_step      <= STEP_PC;
                default:  r_job_valid <= 1'b0;
            endcase
        end
    end

    // compose the next result
    logic [6:0]  bank_msb, bank_lsb;
    logic [3:0]  ch4;
    logic [DATA_W-1:0] n_out_data;
    logic        n_out_last;

    always_comb begin
        bank_msb = r_fwd_msb ? r_val : (r_rd_msb_v ? r_rd_msb : 7'd0);
        bank_lsb = r_fwd_lsb ? r_val : (r_rd_lsb_v ? r_rd_lsb : 7'd0);
        ch4      = 4'(r_ch);
        unique case (r_step)
            STEP_MSB: begin
                n_out_data = {CC_LENGTH, bank_msb, CC_BANK_MSB, CC_NIBBLE, ch4};
                n_out_last = 1'b0;
            end
            STEP_LSB: begin
                n_out_data = {CC_LENGTH, bank_lsb, CC_BANK_LSB, CC_NIBBLE, ch4};
                n_out_last = 1'b0;
            end
            default: begin
                n_out_data = {PC_LENGTH, 7'd0, r_prog, PC_NIBBLE, ch4};
                n_out_last = 1'b1;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_job_valid) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // checks
    a_mid_is_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[23:22] == CC_LENGTH)
        else $error("non-final result is not a control change");

    a_job_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |-> r_job_valid)
        else $error("bank sequence cut short");

    a_pc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[7:4] == PC_NIBBLE)
        else $error("final result is not a program change");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && (r_step != STEP_PC) |-> !o_s_axis_tready)
        else $error("input taken while bank sequence pending");

endmodule

// ===== dv/tb_midi_cc_to_program_bank_translator.sv =====
// self-checking testbench for the midi controller to program/bank translator
module tb_midi_cc_to_program_bank_translator;
    import ccpb_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;

    // one emitted midi message as seen on the output stream
    typedef struct {
        logic [7:0] status;
        logic [6:0] first;
        logic [6:0] second;
        logic [1:0] length;
        logic       last;
    } t_midi_msg;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_wdata;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    // status_byte[7:0], first_data[14:8], second_data[21:15], byte_count[23:22]
    logic [DATA_W-1:0] i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    // out_status[7:0], out_first[14:8], out_second[21:15], out_length[23:22]
    logic [DATA_W-1:0] o_m_axis_tdata;
    logic              o_m_axis_tlast;

    // predictor state
    logic [6:0] msb_bank[DEF_CHANNELS] = '{default: '0};
    logic [6:0] lsb_bank[DEF_CHANNELS] = '{default: '0};
    logic       out_enable_model = 1'b0;
    t_midi_msg  expected_msgs[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  traffic_gaps;
    bit  hold_request;

    midi_cc_to_program_bank_translator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_midi_cc_to_program_bank_translator NOT OK");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pack_midi(logic [7:0] status, logic [6:0] ctl,
                                                    logic [6:0] val, logic [1:0] count);
        return {count, val, ctl, status};
    endfunction

    task automatic push_msg(logic [7:0] status, logic [6:0] first, logic [6:0] second,
                            logic [1:0] length, logic last);
        t_midi_msg m;
        m.status = status;
        m.first  = first;
        m.second = second;
        m.length = length;
        m.last   = last;
        expected_msgs.insert(expected_msgs.size(), m);
    endtask

    // cc0 msb, cc32 lsb, then program change 0 on one channel
    task automatic push_bank_run(logic [3:0] ch);
        push_msg({CC_NIBBLE, ch}, CC_BANK_MSB, msb_bank[ch], CC_LENGTH, 1'b0);
        push_msg({CC_NIBBLE, ch}, CC_BANK_LSB, lsb_bank[ch], CC_LENGTH, 1'b0);
        push_msg({PC_NIBBLE, ch}, 7'd0, 7'd0, PC_LENGTH, 1'b1);
    endtask

    // predict the messages caused by one accepted input transfer
    task automatic predict_midi(logic [DATA_W-1:0] word);
        logic [7:0] status;
        logic [6:0] ctl;
        logic [6:0] val;
        logic [1:0] count;
        logic [3:0] ch;
        status = word[7:0];
        ctl    = word[14:8];
        val    = word[21:15];
        count  = word[23:22];
        if (count != FULL_COUNT || status[7:4] != CC_NIBBLE)
            return;
        if (ctl >= PC_BASE && ctl < PC_BASE + DEF_CHANNELS) begin
            ch = 4'(ctl - PC_BASE);
            if (out_enable_model)
                push_msg({PC_NIBBLE, ch}, val, 7'd0, PC_LENGTH, 1'b1);
        end else if (ctl >= LSB_BASE && ctl < LSB_BASE + DEF_CHANNELS) begin
            ch = 4'(ctl - LSB_BASE);
            lsb_bank[ch] = val;
            if (out_enable_model)
                push_bank_run(ch);
        end else if (ctl >= MSB_BASE && ctl < MSB_BASE + DEF_CHANNELS) begin
            ch = 4'(ctl - MSB_BASE);
            msb_bank[ch] = val;
            if (out_enable_model)
                push_bank_run(ch);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // compare one output transfer with the oldest expected message
    task automatic check_msg();
        t_midi_msg m;
        if (expected_msgs.size() == 0) begin
            $error("unexpected output transfer: tdata %h tlast %b",
                   o_m_axis_tdata, o_m_axis_tlast);
            fail_count++;
            return;
        end
        m = expected_msgs.pop_front();
        check_field("out_status", m.status, o_m_axis_tdata[7:0]);
        check_field("out_first", m.first, o_m_axis_tdata[14:8]);
        check_field("out_second", m.second, o_m_axis_tdata[21:15]);
        check_field("out_length", m.length, o_m_axis_tdata[23:22]);
        check_field("last_of_run", m.last, o_m_axis_tlast);
    endtask

    // monitor: check output transfers, predict input transfers, track config
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_msg();
            if (i_s_axis_tvalid && o_s_axis_tready)
                predict_midi(i_s_axis_tdata);
            if (i_cfg_we)
                out_enable_model = i_cfg_wdata;
        end
    end

    // receiver ready: random stall bursts, plus one long hold on request
    initial begin : rx_ready_gen
        int gap_left;
        int hold_left;
        bit hold_taken;
        gap_left        = 0;
        hold_left       = 0;
        hold_taken      = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_m_axis_tready <= 1'b0;
            end else if (traffic_gaps && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(0, 7);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one message and wait for its transfer; starts and ends at a falling edge
    task automatic send_midi(logic [DATA_W-1:0] word);
        if (traffic_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // stop offering and let all expected messages drain
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_msgs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_output_enable(logic en);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // random message: mostly full control changes on mapped controllers
    function automatic logic [DATA_W-1:0] random_midi();
        logic [7:0] status;
        logic [6:0] ctl;
        logic [1:0] count;
        if ($urandom_range(0, 9) == 0)
            return DATA_W'($urandom);
        status = ($urandom_range(0, 9) < 8) ? {CC_NIBBLE, 4'($urandom)} : 8'($urandom);
        count  = ($urandom_range(0, 9) < 9) ? FULL_COUNT : 2'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: ctl = 7'($urandom_range(1, 16));
            3, 4, 5: ctl = 7'($urandom_range(21, 36));
            6, 7, 8: ctl = 7'($urandom_range(41, 56));
            default: ctl = 7'($urandom);
        endcase
        return pack_midi(status, ctl, 7'($urandom), count);
    endfunction

    // output disabled: nothing emitted, bank stores still land in the tables
    task automatic test_disabled_stores();
        set_output_enable(1'b0);
        send_midi(pack_midi(8'hB0, 7'd1, 7'd127, FULL_COUNT));
        send_midi(pack_midi(8'hB5, 7'd21, 7'h55, FULL_COUNT));
        send_midi(pack_midi(8'hBF, 7'd56, 7'h2A, FULL_COUNT));
        send_midi(pack_midi(8'hB3, 7'd41, 7'd127, FULL_COUNT));
        wait_idle();
    endtask

    // extremes, every controller range, ignored messages
    task automatic test_directed_messages();
        set_output_enable(1'b1);
        send_midi(pack_midi(8'hB0, 7'd1, 7'd127, FULL_COUNT));
        send_midi(pack_midi(8'hBF, 7'd16, 7'd0, FULL_COUNT));
        send_midi(pack_midi(8'hB7, 7'd8, 7'h55, FULL_COUNT));
        send_midi(pack_midi(8'hB0, 7'd21, 7'd127, FULL_COUNT));
        send_midi(pack_midi(8'hB9, 7'd36, 7'h2A, FULL_COUNT));
        send_midi(pack_midi(8'hB0, 7'd41, 7'd0, FULL_COUNT));
        send_midi(pack_midi(8'hB1, 7'd56, 7'd127, FULL_COUNT));
        // channel whose msb was stored while output was off
        send_midi(pack_midi(8'hB2, 7'd40 + 7'd16, 7'h33, FULL_COUNT));
        // unmapped controllers
        send_midi(pack_midi(8'hB0, 7'd0, 7'd127, FULL_COUNT));
        send_midi(pack_midi(8'hB0, 7'd17, 7'd1, FULL_COUNT));
        send_midi(pack_midi(8'hB0, 7'd20, 7'd1, FULL_COUNT));
        send_midi(pack_midi(8'hB0, 7'd37, 7'd1, FULL_COUNT));
        send_midi(pack_midi(8'hB0, 7'd40, 7'd1, FULL_COUNT));
        send_midi(pack_midi(8'hB0, 7'd57, 7'd1, FULL_COUNT));
        send_midi(pack_midi(8'hBF, 7'd127, 7'd127, FULL_COUNT));
        // short messages
        send_midi(pack_midi(8'hB0, 7'd1, 7'd5, 2'd0));
        send_midi(pack_midi(8'hB0, 7'd21, 7'd5, 2'd1));
        send_midi(pack_midi(8'hB0, 7'd41, 7'd5, 2'd2));
        // other status bytes
        send_midi(pack_midi(8'h90, 7'd1, 7'd64, FULL_COUNT));
        send_midi(pack_midi(8'hC0, 7'd21, 7'd64, FULL_COUNT));
        send_midi(pack_midi(8'hFF, 7'd127, 7'd127, FULL_COUNT));
        send_midi(pack_midi(8'h00, 7'd41, 7'd0, FULL_COUNT));
        // back-to-back bank stores and program changes
        send_midi(pack_midi(8'hB4, 7'd45, 7'h7E, FULL_COUNT));
        send_midi(pack_midi(8'hB4, 7'd25, 7'h01, FULL_COUNT));
        send_midi(pack_midi(8'hB4, 7'd5, 7'h40, FULL_COUNT));
        wait_idle();
    endtask

    // long receiver hold while the sender keeps offering bank stores and unmapped controllers
    task automatic test_backpressure();
        int k;
        traffic_gaps = 1'b0;
        hold_request = 1'b1;
        for (k = 0; k < 24; k++)
            send_midi(pack_midi({CC_NIBBLE, 4'($urandom)}, 7'($urandom_range(21, 56)),
                                7'($urandom), FULL_COUNT));
        wait_idle();
        traffic_gaps = 1'b1;
    endtask

    task automatic random_phase(logic en, int count, bit gaps);
        int k;
        set_output_enable(en);
        traffic_gaps = gaps;
        for (k = 0; k < count; k++)
            send_midi(random_midi());
        wait_idle();
    endtask

    // random traffic under several enable settings, quiet tail at the end
    task automatic test_random_traffic();
        random_phase(1'b1, 130, 1'b1);
        random_phase(1'b0, 110, 1'b1);
        random_phase(1'b1, 130, 1'b1);
        random_phase(1'b1, 60, 1'b0);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        i_s_axis_tvalid  = 1'b0;
        i_s_axis_tdata   = '0;
        traffic_gaps     = 1'b1;
        hold_request     = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_disabled_stores();
        test_directed_messages();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (fail_count == 0)
            $display("tb_midi_cc_to_program_bank_translator OK");
        else
            $display("tb_midi_cc_to_program_bank_translator NOT OK");
        $finish;
    end

endmodule
